@@ rtl/inverter_command_frame_builder_assert.svh @@
// Assertion macros for the checker file of the command frame builder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef INVERTER_COMMAND_FRAME_BUILDER_ASSERT_SVH
`define INVERTER_COMMAND_FRAME_BUILDER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ICFB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ICFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/icfb_pkg.sv @@
// Types, constants and CRC functions of the inverter command frame builder.
// No dependencies; the modules of the block and the testbench import this package.
`default_nettype none

package icfb_pkg;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_TICK  = 1'b1
  } icfb_action_t;

  // Gear codes; the fourth code carries no meaning and acts as neutral.
  localparam logic [1:0] GEAR_NEUTRAL = 2'd0;
  localparam logic [1:0] GEAR_DRIVE   = 2'd1;
  localparam logic [1:0] GEAR_REVERSE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPEED_MAX  = 2'd0;
  localparam logic [1:0] CFG_TORQUE_MAX = 2'd1;
  localparam logic [1:0] CFG_POWER_MODE = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_MS = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] SPEED_MAX_RST  = 16'd6000;
  localparam logic [14:0] TORQUE_MAX_RST = 15'd3000;
  localparam logic        POWER_MODE_RST = 1'b0;
  localparam logic [15:0] TIMEOUT_MS_RST = 16'd2000;

  localparam logic [10:0] ID_FIRST  = 11'h410;
  localparam logic [10:0] ID_LAST   = 11'h412;
  localparam logic [7:0]  ACT_CAP   = 8'd60;
  localparam logic [7:0]  ACT_SAT   = 8'd255;

  localparam logic [7:0]  CRC_POLY  = 8'hAD;

  // Product of throttle magnitude and the selected limit, and its quotient by 1000.
  localparam int M_W         = 27;
  localparam int Q_W         = 17;
  // Reciprocal of 1000 scaled by 2^37, rounded up; exact for products below 2^27.
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 37;
  localparam int PROD_W      = M_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 28'd137438954;

  typedef struct packed {
    logic [15:0] speed_max;
    logic [14:0] torque_max;
    logic        power_mode;
    logic [15:0] timeout_ms;
  } icfb_cfg_t;

  typedef struct packed {
    icfb_action_t       action;
    logic [10:0]        frame_id;
    logic signed [10:0] throttle;
    logic [1:0]         gear_request;
    logic               enable_request;
    logic [31:0]        now_ms;
  } icfb_item_t;

  // Word leaving the state stage: scaled product plus the finished frame fields.
  typedef struct packed {
    logic [M_W-1:0] mag;
    logic           spd_en;
    logic           trq_en;
    logic           neg;
    logic [2:0]     state_byte;
    logic [7:0]     alive;
    logic           running;
  } icfb_prod_t;

  typedef struct packed {
    logic [Q_W-1:0] quo;
    logic           spd_en;
    logic           trq_en;
    logic           neg;
    logic [2:0]     state_byte;
    logic [7:0]     alive;
    logic           running;
  } icfb_quo_t;

  typedef struct packed {
    logic [15:0] speed_word;
    logic [15:0] torque_word;
    logic [2:0]  state_byte;
    logic [7:0]  alive_byte;
    logic [7:0]  crc_byte;
    logic        running_flag;
  } icfb_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // CRC-8 over the six frame bytes, low byte of each word first, initial value zero.
  function automatic logic [7:0] crc8_frame(input logic [15:0] speed, input logic [15:0] torque,
                                            input logic [2:0] state, input logic [7:0] alive);
    logic [7:0] c;
    c = 8'd0;
    c = crc8_byte(c, speed[7:0]);
    c = crc8_byte(c, speed[15:8]);
    c = crc8_byte(c, torque[7:0]);
    c = crc8_byte(c, torque[15:8]);
    c = crc8_byte(c, {5'd0, state});
    c = crc8_byte(c, alive);
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/icfb_if.sv @@
// Channel interfaces of the command frame builder: input words and result words.
// Plain valid/ready handshake; no dependencies.
`default_nettype none

interface icfb_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  logic [10:0]       frame_id;
  logic signed [10:0] throttle;
  logic [1:0]        gear_request;
  logic              enable_request;
  logic [31:0]       now_ms;

  modport source (output valid, action, frame_id, throttle, gear_request, enable_request,
                  now_ms, input ready);
  modport sink (input valid, action, frame_id, throttle, gear_request, enable_request,
                now_ms, output ready);
endinterface

interface icfb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_word;
  logic [15:0] torque_word;
  logic [2:0]  state_byte;
  logic [7:0]  alive_byte;
  logic [7:0]  crc_byte;
  logic        running_flag;

  modport source (output valid, speed_word, torque_word, state_byte, alive_byte, crc_byte,
                  running_flag, input ready);
  modport sink (input valid, speed_word, torque_word, state_byte, alive_byte, crc_byte,
                running_flag, output ready);
endinterface

`default_nettype wire

@@ rtl/icfb_ctrl.sv @@
// Input register, event/tick state and the throttle-by-limit multiply stage.
// Depends on icfb_pkg.
`default_nettype none

module icfb_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  icfb_pkg::icfb_cfg_t  cfg,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  icfb_pkg::icfb_item_t in_item,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output icfb_pkg::icfb_prod_t dn_word
);
  import icfb_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  icfb_item_t  s1_item_r;
  logic        p_valid_r, p_valid_nxt;
  icfb_prod_t  p_r, p_nxt;

  logic [7:0]  act_r, act_nxt;
  logic        online_r, online_nxt;
  logic        run_r, run_nxt;
  logic [31:0] tstart_r, tstart_nxt;
  logic [7:0]  alive_r, alive_nxt;

  logic        is_tick, s1_take, p_free;
  logic [1:0]  gear;
  logic        act_nz, id_hit, motion, thr_neg;
  logic [7:0]  act_dec;
  logic [10:0] thr_u, thr_mag;
  logic [15:0] limit;
  logic [31:0] elapsed;

  assign is_tick  = (s1_item_r.action == ACT_TICK);
  assign p_free   = !p_valid_r || dn_ready;
  assign s1_take  = s1_valid_r && (!is_tick || p_free);
  assign in_ready = !s1_valid_r || s1_take;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  // Per-item state update and the multiply; all of it in one stage.
  always_comb begin
    act_nxt    = act_r;
    online_nxt = online_r;
    run_nxt    = run_r;
    tstart_nxt = tstart_r;
    alive_nxt  = alive_r;

    id_hit  = (s1_item_r.frame_id >= ID_FIRST) && (s1_item_r.frame_id <= ID_LAST);
    act_nz  = (act_r != 8'd0);
    act_dec = act_r - 8'd1;
    elapsed = s1_item_r.now_ms - tstart_r;

    gear = s1_item_r.gear_request;
    case (gear)
      GEAR_DRIVE, GEAR_REVERSE: gear = act_nz ? gear : GEAR_NEUTRAL;
      default:                  gear = GEAR_NEUTRAL;
    endcase

    if (s1_take) begin
      if (!is_tick) begin
        online_nxt = 1'b1;
        if (id_hit && act_r != ACT_SAT) begin
          act_nxt = act_r + 8'd1;
        end
      end else begin
        if (act_nz) begin
          act_nxt = (act_dec > ACT_CAP) ? ACT_CAP : act_dec;
        end
        if (online_r) begin
          run_nxt = 1'b1;
        end else if (elapsed > {16'd0, cfg.timeout_ms}) begin
          run_nxt    = 1'b0;
          tstart_nxt = s1_item_r.now_ms;
        end
        online_nxt = 1'b0;
        alive_nxt  = alive_r + 8'd1;
      end
    end

    motion  = s1_item_r.enable_request && (gear != GEAR_NEUTRAL);
    thr_u   = s1_item_r.throttle;
    thr_neg = thr_u[10];
    thr_mag = thr_neg ? (~thr_u + 11'd1) : thr_u;
    limit   = cfg.power_mode ? {1'b0, cfg.torque_max} : cfg.speed_max;

    p_nxt.mag        = M_W'(thr_mag) * M_W'(limit);
    p_nxt.spd_en     = motion && !cfg.power_mode && !thr_neg;
    p_nxt.trq_en     = motion && cfg.power_mode;
    p_nxt.neg        = thr_neg;
    p_nxt.state_byte = {gear == GEAR_REVERSE, gear == GEAR_DRIVE, 1'b1};
    p_nxt.alive      = alive_nxt;
    p_nxt.running    = run_nxt;

    p_valid_nxt = p_valid_r;
    if (p_free) begin
      p_valid_nxt = s1_take && is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      p_valid_r  <= 1'b0;
      act_r      <= 8'd0;
      online_r   <= 1'b0;
      run_r      <= 1'b0;
      tstart_r   <= 32'd0;
      alive_r    <= 8'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      p_valid_r  <= p_valid_nxt;
      act_r      <= act_nxt;
      online_r   <= online_nxt;
      run_r      <= run_nxt;
      tstart_r   <= tstart_nxt;
      alive_r    <= alive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (s1_take && is_tick && p_free) begin
      p_r <= p_nxt;
    end
  end

  assign dn_valid = p_valid_r;
  assign dn_word  = p_r;

endmodule

`default_nettype wire

@@ rtl/icfb_scale.sv @@
// Divide-by-1000 stage: multiplies the product by a scaled reciprocal of 1000.
// Depends on icfb_pkg.
`default_nettype none

module icfb_scale (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  icfb_pkg::icfb_prod_t up_word,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output icfb_pkg::icfb_quo_t  dn_word
);
  import icfb_pkg::*;

  logic              q_valid_r, q_valid_nxt;
  icfb_quo_t         q_r, q_nxt;
  logic [PROD_W-1:0] prod;

  assign up_ready = !q_valid_r || dn_ready;

  always_comb begin
    prod             = PROD_W'(up_word.mag) * PROD_W'(RECIP_1000);
    q_nxt.quo        = prod[RECIP_SHIFT +: Q_W];
    q_nxt.spd_en     = up_word.spd_en;
    q_nxt.trq_en     = up_word.trq_en;
    q_nxt.neg        = up_word.neg;
    q_nxt.state_byte = up_word.state_byte;
    q_nxt.alive      = up_word.alive;
    q_nxt.running    = up_word.running;
    q_valid_nxt      = up_ready ? up_valid : q_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      q_r <= q_nxt;
    end
  end

  assign dn_valid = q_valid_r;
  assign dn_word  = q_r;

endmodule

`default_nettype wire

@@ rtl/icfb_frame.sv @@
// Output stage: selects speed and torque words, applies the sign, adds the CRC.
// Depends on icfb_pkg.
`default_nettype none

module icfb_frame (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    up_valid,
  output logic                   up_ready,
  input  icfb_pkg::icfb_quo_t    up_word,
  output logic                   out_valid,
  input  wire                    out_ready,
  output icfb_pkg::icfb_result_t out_word
);
  import icfb_pkg::*;

  logic         o_valid_r, o_valid_nxt;
  icfb_result_t o_r, o_nxt;
  logic [15:0]  q16;

  assign up_ready = !o_valid_r || out_ready;

  always_comb begin
    q16 = up_word.quo[15:0];
    o_nxt.speed_word   = up_word.spd_en ? q16 : 16'd0;
    o_nxt.torque_word  = up_word.trq_en ? (up_word.neg ? (~q16 + 16'd1) : q16) : 16'd0;
    o_nxt.state_byte   = up_word.state_byte;
    o_nxt.alive_byte   = up_word.alive;
    o_nxt.running_flag = up_word.running;
    o_nxt.crc_byte     = crc8_frame(o_nxt.speed_word, o_nxt.torque_word,
                                    up_word.state_byte, up_word.alive);
    o_valid_nxt        = up_ready ? up_valid : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_word  = o_r;

endmodule

`default_nettype wire

@@ rtl/inverter_command_frame_builder.sv @@
// Top level of the inverter command frame builder: configuration registers and
// the three pipeline stages. Depends on icfb_pkg, icfb_if, icfb_ctrl, icfb_scale, icfb_frame.
//
// Usage. Words arrive on in_ch: an action of zero is a received-frame event, an
// action of one is a periodic tick. Events only update the online flag and the
// activity count and produce no result. Each tick produces exactly one command
// frame word on out_ch, in the order the ticks were accepted.
// Path: a tick accepted on in_ch passes the input register, multiply stage,
// reciprocal stage and output register in order before it shows up on out_ch as valid.
// Throughput: one word per cycle on in_ch, events and ticks alike, as long as a
// tick finds the multiply stage free. The rate is set by the state update in
// the input stage, which every word passes through in order.
// Configuration: cfg_we writes cfg_wdata into the register chosen by cfg_idx
// (0 speed_max, 1 torque_max, 2 power_mode, 3 timeout_ms) at the clock edge.
// Write only while no tick is in flight.
// Reset: rst_n is synchronous and active low. It empties the pipeline, clears
// the activity count, flags, timer start and alive counter, and loads the
// configuration defaults (6000, 3000, speed mode, 2000 ms).
// Stall: when out_ch.ready is low the output register holds its word; the
// stages behind it keep filling, so up to three ticks plus one input word are
// held before in_ch.ready drops.
`default_nettype none

module inverter_command_frame_builder (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [icfb_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  wire [icfb_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  icfb_in_if.sink                               in_ch,
  icfb_out_if.source                            out_ch
);
  import icfb_pkg::*;

  icfb_cfg_t    cfg_r, cfg_nxt;
  icfb_item_t   in_item;
  logic         p_valid, p_ready, q_valid, q_ready;
  icfb_prod_t   p_word;
  icfb_quo_t    q_word;
  icfb_result_t res;

  // Register writes; the index range is fully decoded.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_SPEED_MAX:  cfg_nxt.speed_max  = cfg_wdata;
        CFG_TORQUE_MAX: cfg_nxt.torque_max = cfg_wdata[14:0];
        CFG_POWER_MODE: cfg_nxt.power_mode = cfg_wdata[0];
        CFG_TIMEOUT_MS: cfg_nxt.timeout_ms = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_max  <= SPEED_MAX_RST;
      cfg_r.torque_max <= TORQUE_MAX_RST;
      cfg_r.power_mode <= POWER_MODE_RST;
      cfg_r.timeout_ms <= TIMEOUT_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item.action         = icfb_action_t'(in_ch.action);
  assign in_item.frame_id       = in_ch.frame_id;
  assign in_item.throttle       = in_ch.throttle;
  assign in_item.gear_request   = in_ch.gear_request;
  assign in_item.enable_request = in_ch.enable_request;
  assign in_item.now_ms         = in_ch.now_ms;

  // Stage 1: input register, state update and throttle times limit.
  icfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .dn_valid (p_valid),
    .dn_ready (p_ready),
    .dn_word  (p_word)
  );

  // Stage 2: quotient by 1000.
  icfb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (p_valid),
    .up_ready (p_ready),
    .up_word  (p_word),
    .dn_valid (q_valid),
    .dn_ready (q_ready),
    .dn_word  (q_word)
  );

  // Stage 3: final words, CRC and the output register.
  icfb_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (q_valid),
    .up_ready  (q_ready),
    .up_word   (q_word),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (res)
  );

  assign out_ch.speed_word   = res.speed_word;
  assign out_ch.torque_word  = res.torque_word;
  assign out_ch.state_byte   = res.state_byte;
  assign out_ch.alive_byte   = res.alive_byte;
  assign out_ch.crc_byte     = res.crc_byte;
  assign out_ch.running_flag = res.running_flag;

endmodule

`default_nettype wire

@@ rtl/icfb_checker.sv @@
// Port-level checker of the command frame builder, bound to the top level.
// Depends on icfb_pkg and inverter_command_frame_builder_assert.svh.
`default_nettype none
`include "inverter_command_frame_builder_assert.svh"

module icfb_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_speed,
  input wire [15:0] out_torque,
  input wire [2:0]  out_state,
  input wire [7:0]  out_alive,
  input wire [7:0]  out_crc,
  input wire        out_running
);
  import icfb_pkg::*;

  logic       seen_r;
  logic [7:0] last_alive_r;
  logic       out_take;

  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      last_alive_r <= 8'd0;
    end else if (out_take) begin
      seen_r       <= 1'b1;
      last_alive_r <= out_alive;
    end
  end

  // Every tick advances the alive counter by exactly one, so no frame is lost or repeated.
  `ICFB_ASSERT_SAME(a_alive_step, out_valid && seen_r, out_alive == last_alive_r + 8'd1, "alive counter skipped or repeated")
  `ICFB_ASSERT_SAME(a_crc, out_valid, out_crc == crc8_frame(out_speed, out_torque, out_state, out_alive), "CRC does not match frame bytes")
  `ICFB_ASSERT_SAME(a_state, out_valid, out_state[0] && !(out_state[1] && out_state[2]), "illegal state byte")
  `ICFB_ASSERT_SAME(a_one_cmd, out_valid, (out_speed == 16'd0) || (out_torque == 16'd0), "speed and torque commanded together")
  `ICFB_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_speed) && $stable(out_torque) && $stable(out_crc) && $stable(out_running), "stalled word changed")

endmodule

bind inverter_command_frame_builder icfb_checker u_icfb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_speed   (out_ch.speed_word),
  .out_torque  (out_ch.torque_word),
  .out_state   (out_ch.state_byte),
  .out_alive   (out_ch.alive_byte),
  .out_crc     (out_ch.crc_byte),
  .out_running (out_ch.running_flag)
);

`default_nettype wire

@@ test/inverter_command_frame_builder_tb.sv @@
// Self-checking testbench for the inverter command frame builder.
// Depends on icfb_pkg, icfb_if and the inverter_command_frame_builder top level;
// a scoreboard class predicts every command frame and checks the result channel.
`timescale 1ns / 100ps

module inverter_command_frame_builder_tb;
  import icfb_pkg::*;

  localparam int FULL_THROTTLE = 1000;
  localparam int REPORT_LIMIT  = 10;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_WORDS   = 210;

  // Scoreboard: a cycle-free model of the block. Every accepted input word is
  // run through the model, and each tick leaves one expected command frame in
  // a queue that the result checker drains in order.
  class frame_scoreboard;
    logic [15:0] speed_max;
    logic [14:0] torque_max;
    logic        power_mode;
    logic [15:0] timeout_ms;

    logic [7:0]  activity;
    logic        online;
    logic        running;
    logic [31:0] timer_start;
    logic [7:0]  alive;

    icfb_result_t expected_frames[$];
    int words_in;
    int ticks_in;
    int frames_checked;
    int mismatches;

    function new();
      speed_max   = SPEED_MAX_RST;
      torque_max  = TORQUE_MAX_RST;
      power_mode  = POWER_MODE_RST;
      timeout_ms  = TIMEOUT_MS_RST;
      activity    = '0;
      online      = 1'b0;
      running     = 1'b0;
      timer_start = '0;
      alive       = '0;
      words_in = 0;
      ticks_in = 0;
      frames_checked = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SPEED_MAX:  speed_max  = data;
        CFG_TORQUE_MAX: torque_max = data[14:0];
        CFG_POWER_MODE: power_mode = data[0];
        CFG_TIMEOUT_MS: timeout_ms = data;
        default: ;
      endcase
    endfunction

    function void note_word(icfb_item_t w);
      logic [1:0]   gear;
      int           thr;
      int           scaled;
      logic [15:0]  spd;
      logic [15:0]  trq;
      logic [2:0]   state_bits;
      logic [7:0]   frame_bytes[6];
      logic [7:0]   crc;
      icfb_result_t frame;
      words_in++;
      if (w.action == ACT_FRAME) begin
        online = 1'b1;
        if (w.frame_id >= ID_FIRST && w.frame_id <= ID_LAST && activity != ACT_SAT)
          activity++;
        return;
      end
      ticks_in++;
      // Anything but drive or reverse behaves as neutral.
      gear = (w.gear_request == GEAR_DRIVE || w.gear_request == GEAR_REVERSE) ?
             w.gear_request : GEAR_NEUTRAL;
      if (activity != 0) begin
        activity--;
        if (activity > ACT_CAP) activity = ACT_CAP;
      end else begin
        gear = GEAR_NEUTRAL;
      end
      if (online) begin
        running = 1'b1;
      end else if ((w.now_ms - timer_start) > {16'd0, timeout_ms}) begin
        running = 1'b0;
        timer_start = w.now_ms;
      end
      online = 1'b0;
      alive++;

      thr = int'(w.throttle);
      spd = '0;
      trq = '0;
      if (w.enable_request && gear != GEAR_NEUTRAL) begin
        if (!power_mode) begin
          if (thr > 0) begin
            scaled = thr * int'(speed_max) / FULL_THROTTLE;
            spd = scaled[15:0];
          end
        end else begin
          // Signed division truncates toward zero, as the block does.
          scaled = (thr * int'(torque_max)) / FULL_THROTTLE;
          trq = scaled[15:0];
        end
      end
      state_bits = {gear == GEAR_REVERSE, gear == GEAR_DRIVE, 1'b1};

      frame_bytes = '{spd[7:0], spd[15:8], trq[7:0], trq[15:8], {5'd0, state_bits}, alive};
      crc = '0;
      foreach (frame_bytes[k]) begin
        crc = crc ^ frame_bytes[k];
        repeat (8) crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      end

      frame.speed_word   = spd;
      frame.torque_word  = trq;
      frame.state_byte   = state_bits;
      frame.alive_byte   = alive;
      frame.crc_byte     = crc;
      frame.running_flag = running;
      expected_frames.push_back(frame);
    endfunction

    function void check_frame(icfb_result_t got);
      icfb_result_t want;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: frame with no tick waiting: %p", $realtime, got);
        return;
      end
      want = expected_frames.pop_front();
      frames_checked++;
      if (got.speed_word !== want.speed_word || got.torque_word !== want.torque_word ||
          got.state_byte !== want.state_byte || got.alive_byte !== want.alive_byte ||
          got.crc_byte !== want.crc_byte || got.running_flag !== want.running_flag) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: frame %0d mismatch", $realtime, frames_checked);
          $display("  expected speed %h torque %h state %h alive %h crc %h running %b",
                   want.speed_word, want.torque_word, want.state_byte, want.alive_byte,
                   want.crc_byte, want.running_flag);
          $display("  actual   speed %h torque %h state %h alive %h crc %h running %b",
                   got.speed_word, got.torque_word, got.state_byte, got.alive_byte,
                   got.crc_byte, got.running_flag);
        end
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  typedef struct {
    logic [15:0] speed_max;
    logic [15:0] torque_max;
    logic [15:0] power_mode;
    logic [15:0] timeout_ms;
  } reg_setting_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  icfb_in_if  in_ch ();
  icfb_out_if out_ch ();

  inverter_command_frame_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  frame_scoreboard sb = new();

  // Gap switches: when off, the matching side runs without idle cycles.
  bit          in_gaps_on  = 1'b1;
  bit          out_gaps_on = 1'b1;
  // Set by the stimulus to force a back-to-back burst on the input side.
  bit          burst_mode  = 1'b0;
  // Set by the stimulus to make the result side hold off for a long stretch.
  bit          hold_results = 1'b0;
  // Millisecond clock that ticks carry; it mostly moves forward.
  logic [31:0] clock_ms = '0;
  int          idle_cycles = 0;
  int          settings_used = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every input of the block has a known value from time zero.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_FRAME;
    in_ch.frame_id = '0;
    in_ch.throttle = '0;
    in_ch.gear_request = GEAR_NEUTRAL;
    in_ch.enable_request = 1'b0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
  end

  // Flip the gap switches now and then, so that stretches with and without
  // idle cycles alternate on both sides and land on every pipeline phase.
  initial begin : gap_switcher
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: a run that stops moving words on both channels is a failure.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d frames still expected",
                 $realtime, IDLE_LIMIT, sb.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side. Ready is raised at a falling edge and the frame is taken at
  // the rising edge where valid and ready are both high. Each frame first draws
  // a random stall, or the long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int           stall;
    icfb_result_t got;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        stall = HOLD_CYCLES;
        hold_results = 1'b0;
      end else begin
        stall = out_gaps_on ? $urandom_range(0, 5) : 0;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.speed_word   = out_ch.speed_word;
      got.torque_word  = out_ch.torque_word;
      got.state_byte   = out_ch.state_byte;
      got.alive_byte   = out_ch.alive_byte;
      got.crc_byte     = out_ch.crc_byte;
      got.running_flag = out_ch.running_flag;
      sb.check_frame(got);
    end
  end

  // Offer one input word. The word goes on the channel at a falling edge and
  // counts as taken at the first rising edge that sees ready high. Valid stays
  // up across back-to-back words.
  task automatic send_word(input icfb_item_t w);
    int gap;
    gap = (in_gaps_on && !burst_mode) ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.action         = w.action;
    in_ch.frame_id       = w.frame_id;
    in_ch.throttle       = w.throttle;
    in_ch.gear_request   = w.gear_request;
    in_ch.enable_request = w.enable_request;
    in_ch.now_ms         = w.now_ms;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(w);
  endtask

  // Received-frame event. The tick-only fields carry noise, which the block
  // has to ignore.
  function automatic icfb_item_t frame_event(input logic [10:0] id);
    icfb_item_t w;
    w.action         = ACT_FRAME;
    w.frame_id       = id;
    w.throttle       = 11'($urandom_range(0, 2047));
    w.gear_request   = 2'($urandom_range(0, 3));
    w.enable_request = 1'($urandom_range(0, 1));
    w.now_ms         = $urandom;
    return w;
  endfunction

  function automatic icfb_item_t tick_word(input int thr, input logic [1:0] gear,
                                           input logic en, input logic [31:0] now);
    icfb_item_t w;
    w.action         = ACT_TICK;
    w.frame_id       = 11'($urandom_range(0, 2047));
    w.throttle       = thr[10:0];
    w.gear_request   = gear;
    w.enable_request = en;
    w.now_ms         = now;
    return w;
  endfunction

  // Mostly ids that count as inverter activity, otherwise any id at all.
  function automatic logic [10:0] pick_id();
    return ($urandom_range(0, 3) != 0) ? 11'($urandom_range(ID_FIRST, ID_LAST))
                                       : 11'($urandom_range(0, 2047));
  endfunction

  // Advance the millisecond clock. Steps are scaled to the current timeout so
  // that running both holds and clears; zero steps and wild jumps happen too.
  function automatic logic [31:0] next_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      ;
    else if (r < 60)
      clock_ms = clock_ms + $urandom_range(0, 500);
    else if (r < 95)
      clock_ms = clock_ms + $urandom_range(0, 2 * int'(sb.timeout_ms) + 2);
    else
      clock_ms = $urandom;
    return clock_ms;
  endfunction

  // Tick with random content: throttle mostly inside its stated range, gears
  // weighted toward drive and reverse, enable mostly on.
  function automatic icfb_item_t random_tick();
    int         thr;
    int         r;
    logic [1:0] gear;
    thr = ($urandom_range(0, 6) != 0) ? int'($urandom_range(0, 2000)) - FULL_THROTTLE
                                      : int'($urandom_range(0, 2047));
    r = $urandom_range(0, 9);
    if (r < 4)
      gear = GEAR_DRIVE;
    else if (r < 8)
      gear = GEAR_REVERSE;
    else if (r < 9)
      gear = GEAR_NEUTRAL;
    else
      gear = ~GEAR_NEUTRAL;
    return tick_word(thr, gear, $urandom_range(0, 6) != 0, next_now());
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    sb.write_reg(idx, data);
  endtask

  // Writes all four registers back to back. Only called with the block idle.
  task automatic apply_setting(input reg_setting_t s);
    write_reg(CFG_SPEED_MAX,  s.speed_max);
    write_reg(CFG_TORQUE_MAX, s.torque_max);
    write_reg(CFG_POWER_MODE, s.power_mode);
    write_reg(CFG_TIMEOUT_MS, s.timeout_ms);
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Hold the input side until every expected frame is out, then let the
  // pipeline settle so that trailing events have been taken in as well.
  // Valid drops first, so the last word is not offered a second time.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic. Most of it is well-formed: a burst of received frames that
  // feeds the activity count, followed by ticks that use it. The rest is ticks
  // alone, which age the running timeout, and unordered noise.
  task automatic run_traffic(input int quota);
    int first;
    int r;
    int n_ev;
    int n_tk;
    first = sb.words_in;
    while (sb.words_in - first < quota) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n_ev = $urandom_range(1, 6);
        n_tk = $urandom_range(1, n_ev + 1);
        repeat (n_ev) send_word(frame_event(pick_id()));
        repeat (n_tk) send_word(random_tick());
      end else if (r < 85) begin
        repeat ($urandom_range(1, 4)) send_word(random_tick());
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 1))
            send_word(frame_event(11'($urandom_range(0, 2047))));
          else
            send_word(random_tick());
        end
      end
    end
  endtask

  initial begin : stimulus
    reg_setting_t plan[6];
    icfb_item_t   directed[$];

    plan[0] = '{16'hFFFF, 16'h7FFF, 16'h0000, 16'd1};
    // Upper data bits of the narrow registers are set and must be dropped.
    plan[1] = '{16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    plan[2] = '{16'd0, 16'h8000, 16'hFFFE, 16'd0};
    plan[3] = '{16'd6000, 16'd3000, 16'd1, 16'd2000};
    plan[4] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    plan[5] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(1, 3000))};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part with the reset settings. The first tick comes with a zero
    // activity count, so its drive request must fall back to neutral.
    directed.push_back(tick_word(FULL_THROTTLE, GEAR_DRIVE, 1'b1, 32'd0));
    // Ids just outside the counted window only mark the inverter online.
    directed.push_back(frame_event(ID_FIRST - 11'd1));
    directed.push_back(frame_event(ID_LAST + 11'd1));
    directed.push_back(frame_event(11'h7FF));
    directed.push_back(frame_event(11'h000));
    repeat (2) begin
      directed.push_back(frame_event(ID_FIRST));
      directed.push_back(frame_event(ID_FIRST + 11'd1));
      directed.push_back(frame_event(ID_LAST));
    end
    directed.push_back(tick_word(FULL_THROTTLE, GEAR_DRIVE, 1'b1, 32'd100));
    directed.push_back(tick_word(-FULL_THROTTLE, GEAR_REVERSE, 1'b1, 32'd200));
    // Throttle beyond its stated range is used as it is.
    directed.push_back(tick_word(1023, GEAR_DRIVE, 1'b1, 32'd300));
    directed.push_back(tick_word(-1024, GEAR_REVERSE, 1'b1, 32'd400));
    // The unused gear code acts as neutral.
    directed.push_back(tick_word(600, ~GEAR_NEUTRAL, 1'b1, 32'd500));
    directed.push_back(tick_word(600, GEAR_DRIVE, 1'b0, 32'd600));
    // No frames for longer than the timeout clears running; then the timer
    // difference has to wrap around the top of the 32-bit range.
    directed.push_back(tick_word(1, GEAR_NEUTRAL, 1'b1, 32'd2601));
    directed.push_back(tick_word(0, GEAR_DRIVE, 1'b1, 32'hFFFF_FFFF));
    directed.push_back(tick_word(0, GEAR_DRIVE, 1'b1, 32'd5));
    foreach (directed[k]) send_word(directed[k]);
    clock_ms = 32'd5;
    drain();

    foreach (plan[p]) begin
      apply_setting(plan[p]);
      if (p == 0) begin
        // Saturate the activity count, then let ticks pull it down to the cap.
        repeat (260) send_word(frame_event(11'($urandom_range(ID_FIRST, ID_LAST))));
        repeat (3) send_word(random_tick());
      end
      if (p == 1) begin
        // Back pressure: the result side holds off while ticks keep coming at
        // full rate, so the pipeline fills and the input side has to stall.
        hold_results = 1'b1;
        burst_mode = 1'b1;
        repeat (30) send_word(random_tick());
        burst_mode = 1'b0;
      end
      run_traffic(PHASE_WORDS);
      drain();
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input words (%0d ticks, %0d received frames) over %0d settings.",
             sb.words_in, sb.ticks_in, sb.words_in - sb.ticks_in, settings_used + 1);
    $display("Compared %0d command frames, %0d mismatches, %0d frames missing.",
             sb.frames_checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
